FILE: rtl/utdc_pkg.sv
// Shared types and constants for the USB TD chain status checker.
`timescale 1ns / 1ps
package utdc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int LEN_W           = 11;
  localparam int REPORT_W        = 16;
  localparam logic [LEN_W-1:0] LEN_MASK = 11'h7FF;

  // status_flags bit positions
  localparam int ST_ACTIVE   = 0;
  localparam int ST_STALLED  = 1;
  localparam int ST_BABBLE   = 2;
  localparam int ST_CRC      = 3;
  localparam int ST_BUFFER   = 4;
  localparam int ST_BITSTUFF = 5;

  // error_flags bit positions
  localparam int ERR_BABBLE   = 0;
  localparam int ERR_STALL    = 1;
  localparam int ERR_CRC      = 2;
  localparam int ERR_BUFFER   = 3;
  localparam int ERR_BITSTUFF = 4;
  localparam int ERR_TIMEOUT  = 5;
  localparam int ERR_NOT_EXEC = 6;
  localparam int ERR_SYSTEM   = 7;

  typedef struct packed {
    logic [5:0]       status_flags;
    logic [1:0]       error_count;
    logic             data_toggle;
    logic [LEN_W-1:0] actual_len_raw;
    logic             is_setup;
    logic             short_packet;
    logic [LEN_W-1:0] expected_len;
    logic             last_td;
    logic             hc_halted;
  } td_item_t;

  typedef struct packed {
    logic                finished;
    logic [7:0]          error_flags;
    logic                next_toggle;
    logic [REPORT_W-1:0] complete_bytes;
  } td_result_t;

  typedef struct packed {
    logic chain_started;
    logic skipping_rest;
    logic toggle_reg;
  } chain_flags_t;

endpackage

FILE: rtl/utdc_eval.sv
// Per-descriptor status decode, toggle tracking and byte count update.
`timescale 1ns / 1ps
module utdc_eval import utdc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  td_item_t               item,
  input  chain_flags_t           flags,
  input  logic [COUNT_WIDTH-1:0] byte_count,
  input  logic                   low_speed,
  output logic                   emit,
  output td_result_t             result,
  output chain_flags_t           flags_next,
  output logic [COUNT_WIDTH-1:0] byte_count_next
);

  logic                   toggle_base;
  logic [COUNT_WIDTH-1:0] count_base;
  logic [LEN_W-1:0]       len;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH+REPORT_W-1:0] count_ext;
  logic [7:0]             err;
  logic                   fin;
  logic                   stop;

  assign len = (item.actual_len_raw + LEN_W'(1)) & LEN_MASK;
  assign sum = {1'b0, count_base} + (COUNT_WIDTH+1)'(len);
  assign count_ext = (COUNT_WIDTH+REPORT_W)'(byte_count_next);

  always_comb begin
    toggle_base     = flags.chain_started ? flags.toggle_reg : item.data_toggle;
    count_base      = flags.chain_started ? byte_count : '0;
    err             = '0;
    fin             = 1'b1;
    stop            = 1'b0;
    emit            = 1'b0;
    flags_next      = flags;
    byte_count_next = byte_count;

    if (flags.skipping_rest) begin
      if (item.last_td) begin
        flags_next.skipping_rest = 1'b0;
        flags_next.chain_started = 1'b0;
      end
    end else begin
      flags_next.chain_started = 1'b1;
      flags_next.toggle_reg    = toggle_base;
      byte_count_next          = count_base;
      if (item.status_flags[ST_STALLED]) begin
        if (item.status_flags[ST_BABBLE]) begin
          err[ERR_BABBLE] = 1'b1;
        end else if (item.error_count != 2'd0) begin
          err[ERR_STALL] = 1'b1;
        end
        err[ERR_CRC]      = item.status_flags[ST_CRC];
        err[ERR_BUFFER]   = item.status_flags[ST_BUFFER];
        err[ERR_BITSTUFF] = item.status_flags[ST_BITSTUFF];
        err[ERR_TIMEOUT]  = (item.error_count == 2'd0);
        stop = 1'b1;
      end else if (item.status_flags[ST_ACTIVE]) begin
        err[ERR_NOT_EXEC] = 1'b1;
        fin  = 1'b0;
        stop = 1'b1;
      end else begin
        flags_next.toggle_reg = ~item.data_toggle;
        if (!item.is_setup) begin
          // saturate at the counter's full scale
          byte_count_next = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        end
        stop = !low_speed && item.short_packet && (len < item.expected_len);
      end

      emit = stop || item.last_td;
      if (emit) begin
        if (item.hc_halted) begin
          err[ERR_SYSTEM] = 1'b1;
          fin = 1'b1;
        end
        flags_next.chain_started = 1'b0;
        flags_next.skipping_rest = !item.last_td;
      end
    end

    result.finished    = fin;
    result.error_flags = err;
    result.next_toggle = flags_next.toggle_reg;
    result.complete_bytes = (count_ext > (COUNT_WIDTH+REPORT_W)'({REPORT_W{1'b1}})) ?
                            {REPORT_W{1'b1}} : count_ext[REPORT_W-1:0];
  end

endmodule

FILE: rtl/usb_td_chain_status_check.sv
// Top level: input register, chain state and result register around the status decode.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, in_data           | to block
//  out     | out_valid, out_ready, out_data        | from block
//  cfg     | cfg_valid, cfg_ready, cfg_low_speed   | to block
//
// One descriptor per cycle, but for the stall below; the result of the descriptor that
// ends the walk passes the input register, then the result register.
// Throughput is set by the chain state update, one decode and one add a cycle.
// Reset clears the valid bits, the chain state, the count and low_speed.
// A held result stalls only descriptors that would produce a new result.
`timescale 1ns / 1ps
module usb_td_chain_status_check import utdc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  td_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output td_result_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_low_speed
);

  td_item_t               item;
  logic                   item_valid;
  chain_flags_t           flags;
  chain_flags_t           flags_next;
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  logic                   low_speed;
  logic                   emit;
  td_result_t             result;
  logic                   out_free;
  logic                   item_done;

  utdc_eval #(.COUNT_WIDTH(COUNT_WIDTH)) u_eval (
    .item            (item),
    .flags           (flags),
    .byte_count      (byte_count),
    .low_speed       (low_speed),
    .emit            (emit),
    .result          (result),
    .flags_next      (flags_next),
    .byte_count_next (byte_count_next)
  );

  assign out_free  = !out_valid || out_ready;
  assign item_done = item_valid && (!emit || out_free);
  assign in_ready  = !item_valid || item_done;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      flags      <= '0;
      byte_count <= '0;
      low_speed  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        low_speed <= cfg_low_speed;
      end
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (item_done) begin
        flags      <= flags_next;
        byte_count <= byte_count_next;
      end
      if (out_free) begin
        out_valid <= item_done && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
    if (out_free && item_done && emit) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/utdc_checker.sv
// Port-level checks for the TD chain status checker, bound to the top level.
`timescale 1ns / 1ps
module utdc_checker import utdc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input td_result_t out_data
);

  // a result held under backpressure keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // an unfinished verdict only comes from an active descriptor
  a_unfinished: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.finished |->
      out_data.error_flags == (8'd1 << ERR_NOT_EXEC))
    else $error("unfinished verdict with wrong error bits");

  a_not_exec_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_flags[ERR_NOT_EXEC] |->
      out_data.error_flags[ERR_TIMEOUT:ERR_BABBLE] == '0)
    else $error("not executed reported with transfer errors");

endmodule

bind usb_td_chain_status_check utdc_checker u_utdc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/usb_td_chain_status_check_tb.sv
// Testbench for the USB TD chain status checker: random chains checked against a chain model.
`timescale 1ns / 1ps
module usb_td_chain_status_check_tb;
  import utdc_pkg::*;

  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam logic [5:0] F_ACTIVE   = 6'(1) << ST_ACTIVE;
  localparam logic [5:0] F_STALLED  = 6'(1) << ST_STALLED;
  localparam logic [5:0] F_BABBLE   = 6'(1) << ST_BABBLE;
  localparam logic [5:0] F_CRC      = 6'(1) << ST_CRC;
  localparam logic [5:0] F_BUFFER   = 6'(1) << ST_BUFFER;
  localparam logic [5:0] F_BITSTUFF = 6'(1) << ST_BITSTUFF;

  // Chain verdict model plus the queue of verdicts still owed by the block.
  class chain_verdict_board;
    bit low_speed;
    bit chain_started;
    bit skipping_rest;
    bit toggle_q;
    logic [CNT_W-1:0] byte_count;
    td_result_t verdicts_due[$];
    int unsigned mismatches;
    int unsigned walked;
    int unsigned verdicts_checked;
    int unsigned saturated;
    int unsigned short_stops;

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    function void note_descriptor(td_item_t d);
      logic [7:0] err;
      logic fin;
      logic stop;
      logic [LEN_W-1:0] len;
      logic [CNT_W:0] sum;
      td_result_t v;
      err = '0;
      fin = 1'b1;
      stop = 1'b0;
      if (skipping_rest) begin
        if (d.last_td) begin
          skipping_rest = 1'b0;
          chain_started = 1'b0;
        end
        return;
      end
      walked++;
      if (!chain_started) begin
        chain_started = 1'b1;
        toggle_q = d.data_toggle;
        byte_count = '0;
      end
      if (d.status_flags[ST_STALLED]) begin
        if (d.status_flags[ST_BABBLE]) err[ERR_BABBLE] = 1'b1;
        else if (d.error_count != 0) err[ERR_STALL] = 1'b1;
        err[ERR_CRC]      = d.status_flags[ST_CRC];
        err[ERR_BUFFER]   = d.status_flags[ST_BUFFER];
        err[ERR_BITSTUFF] = d.status_flags[ST_BITSTUFF];
        err[ERR_TIMEOUT]  = (d.error_count == 0);
        stop = 1'b1;
      end else if (d.status_flags[ST_ACTIVE]) begin
        err[ERR_NOT_EXEC] = 1'b1;
        fin = 1'b0;
        stop = 1'b1;
      end else begin
        len = d.actual_len_raw + 11'd1;  // 2047 wraps to zero bytes
        toggle_q = ~d.data_toggle;
        if (!d.is_setup) begin
          sum = {1'b0, byte_count} + (CNT_W+1)'(len);
          byte_count = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        end
        if (!low_speed && d.short_packet && len < d.expected_len) begin
          stop = 1'b1;
          short_stops++;
        end
      end
      if (!stop && !d.last_td) return;
      if (d.hc_halted) begin
        err[ERR_SYSTEM] = 1'b1;
        fin = 1'b1;
      end
      v.finished       = fin;
      v.error_flags    = err;
      v.next_toggle    = toggle_q;
      v.complete_bytes = byte_count;
      if (&byte_count) saturated++;
      verdicts_due.push_back(v);
      chain_started = 1'b0;
      skipping_rest = !d.last_td;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_verdict(td_result_t got);
      td_result_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: verdict with none outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      compare("finished", 16'(want.finished), 16'(got.finished));
      compare("error_flags", 16'(want.error_flags), 16'(got.error_flags));
      compare("next_toggle", 16'(want.next_toggle), 16'(got.next_toggle));
      compare("complete_bytes", want.complete_bytes, got.complete_bytes);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  td_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  td_result_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_low_speed = 1'b0;

  chain_verdict_board board = new();
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 82;
  int unsigned sent_items;

  usb_td_chain_status_check DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_low_speed (cfg_low_speed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("timeout with %0d verdicts outstanding", board.pending());
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Transfers are sampled with pre-edge values, so ordering within the step is moot.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_verdict(out_data);
      if (in_valid && in_ready) board.note_descriptor(in_data);
      if (cfg_valid && cfg_ready) board.low_speed = cfg_low_speed;
    end
  end

  task automatic send_descriptor(td_item_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off input until every verdict is in, then let the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_low_speed(bit v);
    cfg_valid <= 1'b1;
    cfg_low_speed <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic td_item_t make_td(logic [5:0] st, logic [1:0] ec, logic tog,
                                       logic [10:0] raw, logic setup, logic sp,
                                       logic [10:0] xlen, logic last, logic halted);
    td_item_t d;
    d.status_flags   = st;
    d.error_count    = ec;
    d.data_toggle    = tog;
    d.actual_len_raw = raw;
    d.is_setup       = setup;
    d.short_packet   = sp;
    d.expected_len   = xlen;
    d.last_td        = last;
    d.hc_halted      = halted;
    return d;
  endfunction

  function automatic td_item_t random_noise();
    return make_td(6'($urandom_range(63)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                   11'($urandom_range(LEN_MASK)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 11'($urandom_range(1024)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // Mostly successful descriptors; failures are likelier at the chain tail.
  function automatic td_item_t random_td(bit heavy, bit tail);
    td_item_t d;
    int unsigned pick;
    d = random_noise();
    pick = $urandom_range(99);
    if (heavy || pick >= (tail ? 40 : 8)) d.status_flags[1:0] = 2'b00;
    else if (pick < (tail ? 20 : 4)) d.status_flags[ST_STALLED] = 1'b1;
    else begin
      d.status_flags[ST_STALLED] = 1'b0;
      d.status_flags[ST_ACTIVE] = 1'b1;
    end
    d.hc_halted = ($urandom_range(15) == 0);
    if (heavy) begin
      d.actual_len_raw = 11'($urandom_range(2046, 1900));
      d.is_setup = 1'b0;
    end else begin
      d.is_setup = ($urandom_range(7) == 0);
      case ($urandom_range(3))
        0: d.actual_len_raw = d.expected_len - 11'd1;  // exactly full
        1: d.actual_len_raw = d.expected_len - 11'd2;  // one byte short
        2: d.actual_len_raw = LEN_MASK;                // zero length
        default: d.actual_len_raw = 11'($urandom_range(LEN_MASK));
      endcase
    end
    return d;
  endfunction

  task automatic send_chain(int unsigned n, bit heavy);
    td_item_t d;
    for (int unsigned i = 0; i < n; i++) begin
      d = random_td(heavy, i == n - 1);
      d.last_td = (i == n - 1);
      sent_items++;
      send_descriptor(d);
    end
  endtask

  task automatic random_phase(int unsigned goal);
    sent_items = 0;
    while (sent_items < goal) begin
      if ($urandom_range(99) < 15) begin
        send_descriptor(random_noise());
        sent_items++;
      end else if ($urandom_range(99) < 3) begin
        send_chain($urandom_range(48, 40), 1'b1);  // long enough to saturate the count
      end else begin
        send_chain($urandom_range(6, 1), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_low_speed(1'b0);

    // zero-length single descriptor, then SETUP plus a full one on a halted controller
    send_descriptor(make_td('0, 3, 1, LEN_MASK, 0, 1, 0, 1, 0));
    send_descriptor(make_td(F_BABBLE | F_CRC, 0, 0, 0, 1, 0, 0, 0, 0));
    send_descriptor(make_td('0, 1, 1, 11'd2046, 0, 1, 11'd1024, 1, 1));
    // stall with every error bit, then the rest of the chain is skipped
    send_descriptor(make_td(F_STALLED | F_BABBLE | F_CRC | F_BUFFER | F_BITSTUFF,
                            3, 0, 5, 0, 0, 10, 0, 0));
    send_descriptor(make_td('0, 2, 1, 7, 0, 0, 0, 0, 0));
    send_descriptor(make_td(F_ACTIVE, 1, 0, 7, 0, 0, 0, 1, 1));
    // stall with no retries left, stall with retries on a halted controller
    send_descriptor(make_td(F_STALLED, 0, 1, 100, 0, 0, 0, 1, 0));
    send_descriptor(make_td(F_STALLED | F_BUFFER, 2, 0, 0, 0, 0, 0, 1, 1));
    // active descriptor mid-chain
    send_descriptor(make_td('0, 3, 0, 99, 0, 0, 0, 0, 0));
    send_descriptor(make_td(F_ACTIVE | F_BITSTUFF, 1, 1, 0, 0, 0, 0, 0, 0));
    send_descriptor(make_td('0, 3, 1, 0, 0, 0, 0, 1, 0));
    send_descriptor(make_td(F_ACTIVE, 3, 1, 0, 0, 0, 0, 1, 1));
    // short read one byte under the buffer size
    send_descriptor(make_td('0, 3, 0, 11'd1022, 0, 1, 11'd1024, 0, 0));
    send_descriptor(make_td(F_STALLED, 3, 0, 0, 0, 0, 0, 1, 0));
    // full buffer is not short; zero bytes against one is
    send_descriptor(make_td('0, 3, 1, 11'd1023, 0, 1, 11'd1024, 0, 0));
    send_descriptor(make_td('0, 3, 0, LEN_MASK, 0, 1, 11'd1, 1, 0));
    wait_idle();
    write_low_speed(1'b1);
    // low speed: a short read does not end the walk
    send_descriptor(make_td('0, 3, 1, 11'd0, 0, 1, 11'd1024, 0, 0));
    send_descriptor(make_td('0, 3, 0, 11'd0, 0, 1, 11'd1024, 1, 0));
    wait_idle();

    write_low_speed(1'b0);
    random_phase(450);
    wait_idle();

    send_idle_pct = 82;
    recv_idle_pct = 12;
    write_low_speed(1'b1);
    random_phase(450);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_low_speed(1'b0);
    random_phase(450);
    wait_idle();

    $display("walked %0d descriptors at both speeds, checked %0d verdicts", board.walked,
             board.verdicts_checked);
    $display("%0d short-read stops, %0d saturated counts, %0d mismatches",
             board.short_stops, board.saturated, board.mismatches);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
